FILE: sv/i2cm_pkg.sv
package i2cm_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_S_REL    = 4'd1,
        ST_S_SCLH   = 4'd2,
        ST_S_SDAL   = 4'd3,
        ST_BIT_LOW  = 4'd4,
        ST_BIT_HIGH = 4'd5,
        ST_ACK_LOW  = 4'd6,
        ST_ACK_HIGH = 4'd7,
        ST_P_LOW    = 4'd8,
        ST_P_SCLH   = 4'd9
    } t_step;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd12;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef struct packed {
        logic       command_valid;
        logic [1:0] operation;
        logic [7:0] write_byte;
        logic       ack_after_read;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       nack_seen;
    } t_out_word;

endpackage

FILE: sv/i2cm_seq.sv
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_word    i_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_out_word   o_result
);

    logic [15:0] r_phase_ticks;
    t_step       r_step,  n_step;
    logic [15:0] r_cnt,   n_cnt;
    logic [3:0]  r_bit,   n_bit;
    logic [7:0]  r_shift, n_shift;
    t_op         r_op,    n_op;
    logic        r_ack,   n_ack;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic        r_nack,  n_nack;
    logic [7:0]  r_hold,  n_hold;
    logic        v_enter;
    logic        v_done;

    always_comb begin
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_op    = r_op;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_nack  = r_nack;
        n_hold  = r_hold;
        v_enter = 1'b0;
        v_done  = 1'b0;

        if (r_step == ST_IDLE) begin
            if (i_word.command_valid) begin
                n_op    = t_op'(i_word.operation);
                n_ack   = i_word.ack_after_read;
                n_bit   = 4'd0;
                v_enter = 1'b1;
                case (t_op'(i_word.operation))
                    OP_START: begin
                        n_step = ST_S_REL;
                    end
                    OP_STOP: begin
                        n_step = ST_P_LOW;
                    end
                    default: begin
                        n_shift = (t_op'(i_word.operation) == OP_WRITE) ?
                                  i_word.write_byte : 8'd0;
                        n_step  = ST_BIT_LOW;
                    end
                endcase
            end
        end else if (r_cnt < r_phase_ticks) begin
            n_cnt = r_cnt + 16'd1;
        end else begin
            case (r_step)
                ST_S_REL: begin
                    n_step = ST_S_SCLH; v_enter = 1'b1;
                end
                ST_S_SCLH: begin
                    n_step = ST_S_SDAL; v_enter = 1'b1;
                end
                ST_S_SDAL: begin
                    n_scl = 1'b0; n_step = ST_IDLE; n_cnt = 16'd0; v_done = 1'b1;
                end
                ST_BIT_LOW: begin
                    n_step = ST_BIT_HIGH; v_enter = 1'b1;
                end
                ST_BIT_HIGH: begin
                    if (r_op == OP_WRITE) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end else begin
                        n_shift = {r_shift[6:0], i_word.sda_in};
                    end
                    n_bit   = r_bit + 4'd1;
                    n_step  = (n_bit >= BITS_PER_BYTE) ? ST_ACK_LOW : ST_BIT_LOW;
                    v_enter = 1'b1;
                end
                ST_ACK_LOW: begin
                    n_step = ST_ACK_HIGH; v_enter = 1'b1;
                end
                ST_ACK_HIGH: begin
                    if (r_op == OP_WRITE) begin
                        n_nack = i_word.sda_in;
                    end else begin
                        n_hold = r_shift;
                    end
                    n_scl = 1'b0; n_step = ST_IDLE; n_cnt = 16'd0; v_done = 1'b1;
                end
                ST_P_LOW: begin
                    n_step = ST_P_SCLH; v_enter = 1'b1;
                end
                ST_P_SCLH: begin
                    n_sda = 1'b1; n_step = ST_IDLE; n_cnt = 16'd0; v_done = 1'b1;
                end
                default: begin
                    n_step = ST_IDLE; n_cnt = 16'd0;
                end
            endcase
        end

        if (v_enter) begin
            n_cnt = 16'd1;
            case (n_step)
                ST_S_REL:    n_sda = 1'b1;
                ST_S_SCLH:   n_scl = 1'b1;
                ST_S_SDAL:   n_sda = 1'b0;
                ST_BIT_LOW: begin
                    n_scl = 1'b0;
                    n_sda = (n_op == OP_WRITE) ? n_shift[7] : 1'b1;
                end
                ST_BIT_HIGH: n_scl = 1'b1;
                ST_ACK_LOW: begin
                    n_scl = 1'b0;
                    n_sda = (n_op == OP_WRITE) ? 1'b1 : !n_ack;
                end
                ST_ACK_HIGH: n_scl = 1'b1;
                ST_P_LOW: begin
                    n_scl = 1'b0; n_sda = 1'b0;
                end
                ST_P_SCLH:   n_scl = 1'b1;
                default: begin
                end
            endcase
        end

        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.ready_res = (n_step == ST_IDLE);
        o_result.done_res  = v_done;
        o_result.read_byte = n_hold;
        o_result.nack_seen = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_cnt   <= 16'd0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_op    <= OP_START;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_nack  <= 1'b0;
            r_hold  <= 8'd0;
        end else if (i_step) begin
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_op    <= n_op;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
            r_hold  <= n_hold;
        end
    end

endmodule

FILE: sv/i2c_master_byte_engine.sv
// I2C master bit sequencer. Each accepted input word is one timing tick and
// produces exactly one output word showing the bus lines and status after that
// tick. A new word is accepted every clock cycle while the output register is
// empty or being drained, so the block runs at one tick per cycle; the
// sequencer state and the output register are the only storage on the path.
// Every SCL/SDA phase lasts phase_ticks ticks, written through i_cfg_we.
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic      v_accept;
    t_out_word v_result;
    logic      r_out_valid;
    t_out_word r_out_word;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign v_accept   = i_in_valid && o_in_ready;

    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (v_accept),
        .i_word      (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (v_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (v_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_out_word <= v_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: sv/i2cm_check.sv
module i2cm_check
    import i2cm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_word   o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted word produced no output word");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.done_res |-> o_out_word.ready_res)
        else $error("command completed without returning to idle");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

endmodule

bind i2c_master_byte_engine i2cm_check u_i2cm_check (.*);
